// File: design/refined_drift_displacement_assert.svh
// ----------------------------------------------------------------------------
// Refined drift displacement assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef REFINED_DRIFT_DISPLACEMENT_ASSERT_SVH
`define REFINED_DRIFT_DISPLACEMENT_ASSERT_SVH

// same-cycle implication
`define RDD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define RDD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// File: design/rdd_pkg.sv
// ----------------------------------------------------------------------------
// rdd_pkg
// Shared types and codes of the refined drift displacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package rdd_pkg;

	localparam int WORD_W  = 64;
	localparam int FIELD_W = 32;
	localparam int STEP_W  = 6;
	localparam int REF_W   = 11;
	localparam int STAT_W  = 2;
	localparam int GCD_W   = 63;
	localparam int OP_W    = 2;

	localparam logic [REF_W-1:0] REF_MAX = 11'd1024;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

	localparam logic [OP_W-1:0] OP_MUL = 2'd0;
	localparam logic [OP_W-1:0] OP_DIV = 2'd1;
	localparam logic [OP_W-1:0] OP_GCD = 2'd2;

	typedef struct packed {
		logic        [FIELD_W-1:0] packet_ident;
		logic                      path_mode;
		logic        [STEP_W-1:0]  step_count;
		logic signed [FIELD_W-1:0] horizon_time;
		logic signed [FIELD_W-1:0] base_mass_value;
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] pos_z;
		logic signed [FIELD_W-1:0] mom_x;
		logic signed [FIELD_W-1:0] mom_y;
		logic signed [FIELD_W-1:0] mom_z;
	} rdd_in_t;

	typedef struct packed {
		logic        [STAT_W-1:0] status_code;
		logic signed [WORD_W-1:0] disp_x;
		logic signed [WORD_W-1:0] disp_y;
		logic signed [WORD_W-1:0] disp_z;
		logic signed [WORD_W-1:0] final_x;
		logic signed [WORD_W-1:0] final_y;
		logic signed [WORD_W-1:0] final_z;
		logic        [GCD_W-1:0]  momentum_gcd;
		logic signed [WORD_W-1:0] error_x;
		logic signed [WORD_W-1:0] error_y;
		logic signed [WORD_W-1:0] error_z;
	} rdd_out_t;

	// request to the shared arithmetic unit; operands are magnitudes
	typedef struct packed {
		logic              start;
		logic [OP_W-1:0]   op;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] lim;
	} rdd_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic              ovf;
		logic [WORD_W-1:0] res;
		logic [WORD_W-1:0] rem;
	} rdd_rsp_t;

endpackage

`default_nettype wire

// File: design/rdd_if.sv
// ----------------------------------------------------------------------------
// rdd_in_if / rdd_out_if
// Valid/ready channels carrying one record in and one result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdd_in_if;
	logic             valid;
	logic             ready;
	rdd_pkg::rdd_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rdd_out_if;
	logic              valid;
	logic              ready;
	rdd_pkg::rdd_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/rdd_unit.sv
// ----------------------------------------------------------------------------
// rdd_unit
// Shared iterative unit: shift-add multiply with range check, restoring
// divide, and binary gcd, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rdd_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  rdd_pkg::rdd_req_t req,
	output rdd_pkg::rdd_rsp_t rsp
);
	import rdd_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              ovf_q;
	logic [OP_W-1:0]   op_q;
	logic [WORD_W:0]   acc_q;
	logic [WORD_W:0]   x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W-1:0] lim_q;
	logic [6:0]        cnt_q;
	logic [WORD_W-1:0] res_q;
	logic [WORD_W-1:0] rem_q;

	logic [WORD_W:0]   mul_sum;
	logic [WORD_W:0]   mul_x2;
	logic [WORD_W-1:0] y_rest;
	logic              mul_ovf;
	logic [WORD_W:0]   div_sh;
	logic [WORD_W:0]   div_sub;
	logic              div_ge;
	logic [WORD_W-1:0] gx;

	always_comb begin
		mul_sum = acc_q + (y_q[0] ? x_q : '0);
		mul_x2  = {x_q[WORD_W-1:0], 1'b0};
		y_rest  = y_q >> 1;
		mul_ovf = (mul_sum > {1'b0, lim_q}) ||
			((y_rest != '0) && (mul_x2 > {1'b0, lim_q}));
		div_sh  = {acc_q[WORD_W-1:0], y_q[WORD_W-1]};
		div_ge  = div_sh >= x_q;
		div_sub = div_sh - x_q;
		gx      = x_q[WORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				lim_q  <= req.lim;
				cnt_q  <= '0;
				acc_q  <= '0;
				ovf_q  <= 1'b0;
				x_q    <= {1'b0, (req.op == OP_DIV) ? req.b : req.a};
				y_q    <= (req.op == OP_DIV) ? req.a : req.b;
			end else if (busy_q) begin
				unique case (op_q)
					OP_MUL: begin
						if (mul_ovf) begin
							ovf_q  <= 1'b1;
							res_q  <= '0;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else if (y_rest == '0) begin
							res_q  <= mul_sum[WORD_W-1:0];
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							acc_q <= mul_sum;
							x_q   <= mul_x2;
							y_q   <= y_rest;
						end
					end
					OP_DIV: begin
						acc_q <= div_ge ? div_sub : div_sh;
						y_q   <= {y_q[WORD_W-2:0], div_ge};
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q == 7'd63) begin
							res_q  <= {y_q[WORD_W-2:0], div_ge};
							rem_q  <= div_ge ? div_sub[WORD_W-1:0] : div_sh[WORD_W-1:0];
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					OP_GCD: begin
						priority if (gx == '0) begin
							res_q  <= y_q << cnt_q[5:0];
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else if (y_q == '0) begin
							res_q  <= gx;
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else if (!gx[0] && !y_q[0]) begin
							x_q   <= x_q >> 1;
							y_q   <= y_q >> 1;
							cnt_q <= cnt_q + 7'd1;
						end else if (!gx[0]) begin
							x_q <= x_q >> 1;
						end else if (!y_q[0]) begin
							y_q <= y_q >> 1;
						end else if (gx >= y_q) begin
							x_q <= {1'b0, (gx - y_q) >> 1};
						end else begin
							y_q <= (y_q - gx) >> 1;
						end
					end
					default: begin
						res_q  <= '0;
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.res  = res_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: design/refined_drift_displacement.sv
// Sequence: a rejected record goes from the input transfer through the check
//   step straight to the done state and the output register; a valid record
//   runs its program steps on the shared unit, where each multiply steps over
//   the bits of its second operand, each divide over every dividend bit and each gcd through its binary reduction.
// Throughput: one record at a time; the next is taken once the sequencer is
//   idle, while the previous result may still wait in the output register.
// Reset: arst_n clears the sequencer and output valid, refinement becomes 1.
// ----------------------------------------------------------------------------
// refined_drift_displacement
// Scales one particle record by the refinement register and computes its
// drift displacement, final position, momentum gcd and error numerators
// with one shared multiply/divide/gcd unit under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module refined_drift_displacement #(
	parameter int DATA_WIDTH = 64,
	parameter int MAX_STEPS  = 32
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire [rdd_pkg::REF_W-1:0] cfg_wr_data,
	rdd_in_if.sink                   in_ch,
	rdd_out_if.source                out_ch
);
	import rdd_pkg::*;

	`include "refined_drift_displacement_assert.svh"

	// range limits of the signed DATA_WIDTH arithmetic
	localparam logic [WORD_W-1:0] LIM_POS =
		WORD_W'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
	localparam logic [WORD_W-1:0] LIM_NEG = LIM_POS + 64'd1;
	localparam logic signed [WORD_W-1:0] VAL_MIN = signed'(64'd0 - LIM_NEG);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1;
	localparam logic [1:0] S_WAIT  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	// program steps
	localparam logic [4:0] P_CHECK = 5'd0;
	localparam logic [4:0] P_REF2  = 5'd1;
	localparam logic [4:0] P_POS   = 5'd2;
	localparam logic [4:0] P_MOM   = 5'd3;
	localparam logic [4:0] P_MASS  = 5'd4;
	localparam logic [4:0] P_GCD1  = 5'd5;
	localparam logic [4:0] P_GCD2  = 5'd6;
	localparam logic [4:0] P_DIR   = 5'd7;
	localparam logic [4:0] P_SUBA  = 5'd8;
	localparam logic [4:0] P_RNDA  = 5'd9;
	localparam logic [4:0] P_STA   = 5'd10;
	localparam logic [4:0] P_SUBB  = 5'd11;
	localparam logic [4:0] P_RNDB  = 5'd12;
	localparam logic [4:0] P_STB   = 5'd13;
	localparam logic [4:0] P_DIRM  = 5'd14;
	localparam logic [4:0] P_FIN   = 5'd15;
	localparam logic [4:0] P_TGT   = 5'd16;
	localparam logic [4:0] P_DM    = 5'd17;
	localparam logic [4:0] P_ERR   = 5'd18;

	function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
		mag = v[WORD_W-1] ? (64'd0 - v) : v;
	endfunction

	function automatic logic signed [WORD_W-1:0] from_mag(input logic neg,
		input logic [WORD_W-1:0] m);
		from_mag = neg ? signed'(64'd0 - m) : signed'(m);
	endfunction

	function automatic logic signed [WORD_W-1:0] sx(input logic [FIELD_W-1:0] v);
		sx = signed'({{(WORD_W-FIELD_W){v[FIELD_W-1]}}, v});
	endfunction

	logic [REF_W-1:0]  ref_q;
	logic [1:0]        state_q;
	logic [4:0]        pc_q;
	logic [1:0]        ax_q;
	logic [STAT_W-1:0] stat_q;
	logic              neg_q;
	rdd_in_t           in_q;

	logic signed [WORD_W-1:0] ref2_q;
	logic signed [WORD_W-1:0] mass_q;
	logic signed [WORD_W-1:0] sub_q;
	logic signed [WORD_W-1:0] g_q;
	logic signed [WORD_W-1:0] tmp_q;
	logic signed [WORD_W-1:0] tgt_q;
	logic signed [WORD_W-1:0] pos_q  [3];
	logic signed [WORD_W-1:0] mom_q  [3];
	logic signed [WORD_W-1:0] dir_q  [3];
	logic signed [WORD_W-1:0] disp_q [3];
	logic signed [WORD_W-1:0] fin_q  [3];
	logic signed [WORD_W-1:0] err_q  [3];

	logic     out_valid_q;
	logic     out_load;
	rdd_out_t out_q;

	rdd_req_t u_req;
	rdd_rsp_t u_rsp;

	logic signed [WORD_W-1:0] pos0 [3];
	logic signed [WORD_W-1:0] mom0 [3];
	logic signed [WORD_W-1:0] ref_ext;
	logic signed [WORD_W-1:0] st_ext;
	logic signed [WORD_W-1:0] op_a;
	logic signed [WORD_W-1:0] op_b;
	logic [OP_W-1:0]          u_op;
	logic                     use_unit;
	logic                     op_neg;
	logic                     rec_bad;
	logic                     step_pow2;
	logic [2:0]               step_log;
	logic signed [WORD_W:0]   add_sum;
	logic signed [WORD_W:0]   sub_dif;
	logic                     add_ovf;
	logic                     sub_ovf;
	logic                     mom_min;
	logic                     rnd_up;
	logic signed [WORD_W-1:0] wb_val;
	logic signed [WORD_W-1:0] rnd_val;

	rdd_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.rsp    (u_rsp)
	);

	// record fields, sign-extended to the working width
	always_comb begin
		pos0[0] = sx(in_q.pos_x);
		pos0[1] = sx(in_q.pos_y);
		pos0[2] = sx(in_q.pos_z);
		mom0[0] = sx(in_q.mom_x);
		mom0[1] = sx(in_q.mom_y);
		mom0[2] = sx(in_q.mom_z);
		ref_ext = signed'({{(WORD_W-REF_W){1'b0}}, ref_q});
		st_ext  = signed'({{(WORD_W-STEP_W){1'b0}}, in_q.step_count});
	end

	// record validity; subdivision is a power of two so the substep is a shift
	always_comb begin
		step_log = '0;
		for (int i = 0; i < STEP_W; i++) begin
			if (in_q.step_count[i]) begin
				step_log = 3'(i);
			end
		end
		step_pow2 = (in_q.step_count != '0) &&
			((in_q.step_count & (in_q.step_count - 6'd1)) == '0) &&
			(32'(in_q.step_count) <= 32'(MAX_STEPS));
		rec_bad = (in_q.packet_ident == '0) ||
			(in_q.base_mass_value <= 0) ||
			(in_q.horizon_time <= 0) ||
			!step_pow2 ||
			(ref_q == '0) || (ref_q > REF_MAX) ||
			((in_q.horizon_time & (32'(in_q.step_count) - 32'd1)) != '0);
	end

	// operand selection for the shared unit, one program step at a time
	always_comb begin
		use_unit = 1'b0;
		u_op     = OP_MUL;
		op_a     = '0;
		op_b     = '0;
		mom_min  = (mom_q[0] == VAL_MIN) || (mom_q[1] == VAL_MIN) ||
			(mom_q[2] == VAL_MIN);
		unique case (pc_q)
			P_REF2: begin
				use_unit = 1'b1;
				op_a     = ref_ext;
				op_b     = ref_ext;
			end
			P_POS: begin
				use_unit = 1'b1;
				op_a     = pos0[ax_q];
				op_b     = ref_ext;
			end
			P_MOM: begin
				use_unit = 1'b1;
				op_a     = mom0[ax_q];
				op_b     = ref2_q;
			end
			P_MASS: begin
				use_unit = 1'b1;
				op_a     = sx(in_q.base_mass_value);
				op_b     = ref_ext;
			end
			P_GCD1: begin
				use_unit = !mom_min;
				u_op     = OP_GCD;
				op_a     = signed'(mag(mom_q[0]));
				op_b     = signed'(mag(mom_q[1]));
			end
			P_GCD2: begin
				use_unit = 1'b1;
				u_op     = OP_GCD;
				op_a     = g_q;
				op_b     = signed'(mag(mom_q[2]));
			end
			P_DIR: begin
				use_unit = (g_q != '0);
				u_op     = OP_DIV;
				op_a     = mom_q[ax_q];
				op_b     = g_q;
			end
			P_SUBA, P_TGT: begin
				use_unit = 1'b1;
				op_a     = mom_q[ax_q];
				op_b     = (pc_q == P_TGT) ? sx(in_q.horizon_time) : sub_q;
			end
			P_SUBB: begin
				use_unit = (g_q != '0);
				op_a     = g_q;
				op_b     = sub_q;
			end
			P_RNDA, P_RNDB: begin
				use_unit = (tmp_q != VAL_MIN);
				u_op     = OP_DIV;
				op_a     = tmp_q;
				op_b     = mass_q;
			end
			P_STA, P_STB: begin
				use_unit = 1'b1;
				op_a     = tmp_q;
				op_b     = st_ext;
			end
			P_DIRM: begin
				use_unit = 1'b1;
				op_a     = tmp_q;
				op_b     = dir_q[ax_q];
			end
			P_DM: begin
				use_unit = 1'b1;
				op_a     = disp_q[ax_q];
				op_b     = mass_q;
			end
			default: begin
				use_unit = 1'b0;
			end
		endcase
		op_neg      = op_a[WORD_W-1] ^ op_b[WORD_W-1];
		u_req.start = (state_q == S_ISSUE) && use_unit;
		u_req.op    = u_op;
		u_req.a     = mag(op_a);
		u_req.b     = mag(op_b);
		u_req.lim   = op_neg ? LIM_NEG : LIM_POS;
	end

	// combinational add/sub for final position and error, range checked
	always_comb begin
		add_sum = {pos_q[ax_q][WORD_W-1], pos_q[ax_q]} +
			{disp_q[ax_q][WORD_W-1], disp_q[ax_q]};
		sub_dif = {tmp_q[WORD_W-1], tmp_q} - {tgt_q[WORD_W-1], tgt_q};
		add_ovf = (add_sum > signed'({1'b0, LIM_POS})) ||
			(add_sum < signed'({VAL_MIN[WORD_W-1], VAL_MIN}));
		sub_ovf = (sub_dif > signed'({1'b0, LIM_POS})) ||
			(sub_dif < signed'({VAL_MIN[WORD_W-1], VAL_MIN}));
	end

	// round half to even on the quotient magnitude
	always_comb begin
		rnd_up = (u_rsp.rem > (mass_q >> 1)) ||
			(!mass_q[0] && (u_rsp.rem == (mass_q >> 1)) && u_rsp.res[0]);
		rnd_val = from_mag(neg_q, u_rsp.res + (rnd_up ? 64'd1 : 64'd0));
		wb_val  = from_mag(neg_q, u_rsp.res);
	end

	// a finished record moves into the output register once that is free
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

	// refinement register; the host is to write it only between records, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_W'(1);
		end else if (cfg_wr_en) begin
			ref_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= P_CHECK;
			ax_q        <= '0;
			stat_q      <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the held one once it transfers
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						in_q    <= in_ch.data;
						pc_q    <= P_CHECK;
						ax_q    <= '0;
						stat_q  <= ST_OK;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (use_unit) begin
						// hand the step to the shared unit, keep the result sign
						neg_q   <= op_neg;
						state_q <= S_WAIT;
					end else begin
						unique case (pc_q)
							P_CHECK: begin
								if (rec_bad) begin
									stat_q  <= ST_INVALID;
									state_q <= S_DONE;
								end else begin
									sub_q <= signed'(sx(in_q.horizon_time) >>> step_log);
									pc_q  <= P_REF2;
								end
							end
							P_GCD1: begin
								// a most-negative momentum has no magnitude
								stat_q  <= ST_OVERFLOW;
								state_q <= S_DONE;
							end
							P_DIR: begin
								dir_q[ax_q] <= '0;
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									pc_q <= in_q.path_mode ? P_SUBB : P_SUBA;
								end else begin
									ax_q <= ax_q + 2'd1;
								end
							end
							P_SUBB: begin
								// zero momentum: no directional step
								disp_q[0] <= '0;
								disp_q[1] <= '0;
								disp_q[2] <= '0;
								ax_q      <= '0;
								pc_q      <= P_FIN;
							end
							P_RNDA, P_RNDB: begin
								stat_q  <= ST_INVALID;
								state_q <= S_DONE;
							end
							P_FIN: begin
								if (add_ovf) begin
									stat_q  <= ST_OVERFLOW;
									state_q <= S_DONE;
								end else begin
									fin_q[ax_q] <= add_sum[WORD_W-1:0];
									if (ax_q == 2'd2) begin
										ax_q <= '0;
										pc_q <= P_TGT;
									end else begin
										ax_q <= ax_q + 2'd1;
									end
								end
							end
							P_ERR: begin
								if (sub_ovf) begin
									stat_q  <= ST_OVERFLOW;
									state_q <= S_DONE;
								end else begin
									err_q[ax_q] <= sub_dif[WORD_W-1:0];
									if (ax_q == 2'd2) begin
										state_q <= S_DONE;
									end else begin
										ax_q <= ax_q + 2'd1;
										pc_q <= P_TGT;
									end
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_WAIT: begin
					if (u_rsp.done) begin
						if (u_rsp.ovf) begin
							stat_q  <= ST_OVERFLOW;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ISSUE;
							unique case (pc_q)
								P_REF2: begin
									ref2_q <= wb_val;
									pc_q   <= P_POS;
								end
								P_POS: begin
									pos_q[ax_q] <= wb_val;
									if (ax_q == 2'd2) begin
										ax_q <= '0;
										pc_q <= P_MOM;
									end else begin
										ax_q <= ax_q + 2'd1;
									end
								end
								P_MOM: begin
									mom_q[ax_q] <= wb_val;
									if (ax_q == 2'd2) begin
										ax_q <= '0;
										pc_q <= P_MASS;
									end else begin
										ax_q <= ax_q + 2'd1;
									end
								end
								P_MASS: begin
									mass_q <= wb_val;
									pc_q   <= P_GCD1;
								end
								P_GCD1: begin
									g_q  <= signed'(u_rsp.res);
									pc_q <= P_GCD2;
								end
								P_GCD2: begin
									g_q  <= signed'(u_rsp.res);
									ax_q <= '0;
									pc_q <= P_DIR;
								end
								P_DIR: begin
									dir_q[ax_q] <= wb_val;
									if (ax_q == 2'd2) begin
										ax_q <= '0;
										pc_q <= in_q.path_mode ? P_SUBB : P_SUBA;
									end else begin
										ax_q <= ax_q + 2'd1;
									end
								end
								P_SUBA: begin
									tmp_q <= wb_val;
									pc_q  <= P_RNDA;
								end
								P_RNDA: begin
									tmp_q <= rnd_val;
									pc_q  <= P_STA;
								end
								P_STA: begin
									disp_q[ax_q] <= wb_val;
									if (ax_q == 2'd2) begin
										ax_q <= '0;
										pc_q <= P_FIN;
									end else begin
										ax_q <= ax_q + 2'd1;
										pc_q <= P_SUBA;
									end
								end
								P_SUBB: begin
									tmp_q <= wb_val;
									pc_q  <= P_RNDB;
								end
								P_RNDB: begin
									tmp_q <= rnd_val;
									pc_q  <= P_STB;
								end
								P_STB: begin
									// hold the total step length in tmp
									tmp_q <= wb_val;
									ax_q  <= '0;
									pc_q  <= P_DIRM;
								end
								P_DIRM: begin
									disp_q[ax_q] <= wb_val;
									if (ax_q == 2'd2) begin
										ax_q <= '0;
										pc_q <= P_FIN;
									end else begin
										ax_q <= ax_q + 2'd1;
									end
								end
								P_TGT: begin
									tgt_q <= wb_val;
									pc_q  <= P_DM;
								end
								P_DM: begin
									tmp_q <= wb_val;
									pc_q  <= P_ERR;
								end
								default: begin
									state_q <= S_DONE;
								end
							endcase
						end
					end
				end
				S_DONE: begin
					// advance into the output register once it is free;
					// a faulted record carries only its status
					if (out_load) begin
						state_q           <= S_IDLE;
						out_q.status_code <= stat_q;
						out_q.disp_x      <= (stat_q == ST_OK) ? disp_q[0] : '0;
						out_q.disp_y      <= (stat_q == ST_OK) ? disp_q[1] : '0;
						out_q.disp_z      <= (stat_q == ST_OK) ? disp_q[2] : '0;
						out_q.final_x     <= (stat_q == ST_OK) ? fin_q[0] : '0;
						out_q.final_y     <= (stat_q == ST_OK) ? fin_q[1] : '0;
						out_q.final_z     <= (stat_q == ST_OK) ? fin_q[2] : '0;
						out_q.momentum_gcd <= (stat_q == ST_OK) ? g_q[GCD_W-1:0] : '0;
						out_q.error_x     <= (stat_q == ST_OK) ? err_q[0] : '0;
						out_q.error_y     <= (stat_q == ST_OK) ? err_q[1] : '0;
						out_q.error_z     <= (stat_q == ST_OK) ? err_q[2] : '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready  = (state_q == S_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	// a faulted result carries nothing but its status
	`RDD_ASSERT_IMP(a_fault_clears, out_ch.valid && (out_ch.data.status_code != ST_OK), (out_ch.data.disp_x == '0) && (out_ch.data.final_y == '0) && (out_ch.data.momentum_gcd == '0) && (out_ch.data.error_z == '0))
	// the shared unit is never restarted mid-operation
	`RDD_ASSERT_IMP(a_unit_free, u_req.start, !u_rsp.busy)
	// a transfer in closes the input until the record is finished
	`RDD_ASSERT_NXT(a_busy_after, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

`default_nettype wire
